// ===== src/pe_pkg.sv =====
// ----------------------------------------------------------------------------
// pe_pkg: shared types, constants and helpers for the polynomial evaluator
// Operation codes, store geometry and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package pe_pkg;

    localparam int TERMS   = 32;
    localparam int IDX_W   = $clog2(TERMS);
    localparam int MARKS_W = 32;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_CLR  = 2'd2;
    localparam logic [1:0] OP_EVAL = 2'd3;

    localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN = -64'sh0000_0000_8000_0000;

    typedef logic signed [31:0] t_q;
    typedef logic [IDX_W-1:0]   t_idx;

    typedef struct packed {
        t_q   val;
        logic sat;
    } t_sat;

    // Clamp a wide signed value to the 32-bit range.
    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > Q_MAX) begin
            r.sat = 1'b1;
            r.val = Q_MAX[31:0];
        end else if (v < Q_MIN) begin
            r.sat = 1'b1;
            r.val = Q_MIN[31:0];
        end
        return r;
    endfunction

    // Highest set mark, zero when none is set.
    function automatic logic [4:0] degree_of(input logic [MARKS_W-1:0] marks);
        logic [4:0] d;
        d = '0;
        for (int k = 0; k < MARKS_W; k++) begin
            if (marks[k]) d = 5'(k);
        end
        return d;
    endfunction

endpackage

// ===== src/pe_if.sv =====
// ----------------------------------------------------------------------------
// pe_in_if / pe_out_if: item channels of the polynomial evaluator
// Valid/ready handshake with the operation or result payload.
// ----------------------------------------------------------------------------
interface pe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  exponent;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;

    modport source (output valid, operation, exponent, coef_value, point_x, input ready);
    modport sink   (input valid, operation, exponent, coef_value, point_x, output ready);
endinterface

interface pe_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic [4:0]  poly_degree;
    logic        overflow;

    modport source (output valid, result_value, poly_degree, overflow, input ready);
    modport sink   (input valid, result_value, poly_degree, overflow, output ready);
endinterface

// ===== src/pe_coef_mem.sv =====
// ----------------------------------------------------------------------------
// pe_coef_mem: coefficient store
// One write port, one registered read port; per-entry valid bits make a
// cleared entry read as zero.
// ----------------------------------------------------------------------------
module pe_coef_mem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clr,
    input  logic        i_we,
    input  pe_pkg::t_idx i_waddr,
    input  pe_pkg::t_q  i_wdata,
    input  pe_pkg::t_idx i_raddr,
    output pe_pkg::t_q  o_rdata
);
    import pe_pkg::*;

    t_q              mem [TERMS];
    logic [TERMS-1:0] r_valid;
    t_q              r_rdata;
    logic            r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) r_valid[i_waddr] <= 1'b1;
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== src/pe_mac.sv =====
// ----------------------------------------------------------------------------
// pe_mac: Horner step unit
// Each step registers the product, then shifts, clamps, adds and clamps.
// ----------------------------------------------------------------------------
module pe_mac (
    input  logic       i_clk,
    input  logic       i_start,
    input  pe_pkg::t_q i_x,
    input  logic       i_mul_en,
    input  logic       i_add_en,
    input  pe_pkg::t_q i_coef,
    output pe_pkg::t_q o_acc,
    output logic       o_sat
);
    import pe_pkg::*;

    t_q                r_x;
    t_q                r_acc;
    logic              r_sat;
    logic signed [63:0] r_prod;
    t_sat              prod_s;
    t_sat              sum_s;

    always_comb begin
        prod_s = sat32(r_prod >>> 16);
        sum_s  = sat32(64'(prod_s.val) + 64'(i_coef));
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_add_en) begin
            r_acc <= sum_s.val;
            r_sat <= r_sat | prod_s.sat | sum_s.sat;
        end
        if (i_mul_en) r_prod <= 64'(r_acc) * 64'(r_x);
    end

    assign o_acc = r_acc;
    assign o_sat = r_sat;

endmodule

// ===== src/polynomial_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// polynomial_evaluator_top: Q16.16 coefficient store with Horner evaluation
//
//   channel  dir  payload                                  handshake
//   i_in     in   operation, exponent, coef_value, point_x valid/ready
//   o_out    out  result_value, poly_degree, overflow      valid/ready
//
// One item at a time. Set and clear each act in a single state, add reads then writes back,
// evaluate runs from the current degree d down to term zero: each Horner step is a
// coefficient read plus a registered multiply, then a clamp-and-add.
// Reset clears the store at once through per-entry valid bits.
// A result that is not taken holds the block in its output state.
// ----------------------------------------------------------------------------
module polynomial_evaluator_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pe_in_if.sink    i_in,
    pe_out_if.source o_out
);
    import pe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SET  = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_ARD  = 3'd3;
    localparam logic [2:0] S_AWR  = 3'd4;
    localparam logic [2:0] S_EMUL = 3'd5;
    localparam logic [2:0] S_EADD = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_op;
    logic [4:0]         r_exp;
    logic               r_exp_ok;
    t_q                 r_val;
    t_idx               r_i;
    logic [MARKS_W-1:0] r_marks;
    logic               r_sat;

    logic               r_out_valid;
    t_q                 r_out_value;
    logic [4:0]         r_out_degree;
    logic               r_out_ovf;

    logic  accept;
    logic  mem_we;
    t_q    mem_wdata;
    t_idx  mem_raddr;
    t_q    mem_rdata;
    t_q    mac_acc;
    logic  mac_sat;
    t_sat  add_s;
    logic  out_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        add_s     = sat32(64'(mem_rdata) + 64'(r_val));
        mem_we    = 1'b0;
        mem_wdata = r_val;
        mem_raddr = r_i;
        if (r_state == S_SET && r_exp_ok) mem_we = 1'b1;
        if (r_state == S_AWR && r_exp_ok) begin
            mem_we    = 1'b1;
            mem_wdata = add_s.val;
        end
        if (r_state == S_ARD) mem_raddr = IDX_W'(r_exp);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in.operation)
                        OP_SET:  n_state = S_SET;
                        OP_ADD:  n_state = S_ARD;
                        OP_CLR:  n_state = S_CLR;
                        OP_EVAL: n_state = S_EMUL;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SET, S_CLR, S_AWR: n_state = S_OUT;
            S_ARD:  n_state = S_AWR;
            S_EMUL: n_state = S_EADD;
            S_EADD: n_state = (r_i == '0) ? S_OUT : S_EMUL;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_marks <= '0;
            if (mem_we) r_marks[r_exp] <= (mem_wdata != '0);
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in.operation;
            r_exp    <= i_in.exponent;
            r_exp_ok <= (32'(i_in.exponent) < TERMS);
            r_val    <= i_in.coef_value;
            r_sat    <= 1'b0;
            // Terms above the degree are zero and leave the sum at zero.
            r_i      <= IDX_W'(degree_of(r_marks));
        end else if (r_state == S_EADD && r_i != '0) begin
            r_i <= r_i - 1'b1;
        end
        if (r_state == S_AWR && r_exp_ok) r_sat <= add_s.sat;
        if (r_state == S_OUT && out_free) begin
            r_out_value  <= (r_op == OP_EVAL) ? mac_acc : '0;
            r_out_degree <= degree_of(r_marks);
            r_out_ovf    <= (r_op == OP_EVAL) ? mac_sat : r_sat;
        end
    end

    pe_coef_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (r_state == S_CLR),
        .i_we    (mem_we),
        .i_waddr (IDX_W'(r_exp)),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pe_mac u_mac (
        .i_clk    (i_clk),
        .i_start  (accept && i_in.operation == OP_EVAL),
        .i_x      (i_in.point_x),
        .i_mul_en (r_state == S_EMUL),
        .i_add_en (r_state == S_EADD),
        .i_coef   (mem_rdata),
        .o_acc    (mac_acc),
        .o_sat    (mac_sat)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.poly_degree  = r_out_degree;
    assign o_out.overflow     = r_out_ovf;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("item accepted while another is in flight");

    a_horner_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EADD |=> (r_state == S_EMUL || r_state == S_OUT))
        else $error("Horner step left the loop unexpectedly");

    a_clear_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |=> r_marks == '0)
        else $error("clear left nonzero marks");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !out_free |=> r_state == S_OUT)
        else $error("result dropped while output stalled");

endmodule

// ===== tb/tb_polynomial_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// tb_polynomial_evaluator_top: self-checking bench for the polynomial evaluator
// Sends set, add, clear and evaluate items in bursts while the result side
// stalls on its own pattern. Every accepted item is applied to a local copy
// of the coefficient store, and every result is checked in order against the
// value, degree and overflow flag predicted from that copy.
// ----------------------------------------------------------------------------

typedef struct {
    pe_pkg::t_q value;
    logic [4:0] degree;
    logic       overflow;
} t_poly_answer;

class poly_scoreboard;
    pe_pkg::t_q   coefs[pe_pkg::TERMS];
    logic [31:0]  marks;
    t_poly_answer answers[$];
    int           errors;

    function new();
        wipe();
        errors = 0;
    endfunction

    function void wipe();
        foreach (coefs[k]) coefs[k] = '0;
        marks = '0;
    endfunction

    function void store_coef(input int idx, input pe_pkg::t_q v);
        coefs[idx] = v;
        marks[idx] = (v != 0);
    endfunction

    // Clamp to the signed 32-bit range and flag any clipping.
    function logic signed [63:0] clamp_q(input logic signed [63:0] v, inout logic sat);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            sat = 1'b1;
            return 64'sh0000_0000_7FFF_FFFF;
        end
        if (v < -64'sh0000_0000_8000_0000) begin
            sat = 1'b1;
            return -64'sh0000_0000_8000_0000;
        end
        return v;
    endfunction

    function int pending_count();
        return answers.size();
    endfunction

    // Apply one accepted item to the local store and queue its answer.
    function void apply_operation(input logic [1:0] op, input logic [4:0] exponent,
                                  input pe_pkg::t_q coef_value, input pe_pkg::t_q point_x);
        t_poly_answer       a;
        logic signed [63:0] acc;
        logic signed [63:0] px;
        logic               sat;
        sat     = 1'b0;
        a.value = '0;
        case (op)
            pe_pkg::OP_SET: begin
                if (exponent < pe_pkg::TERMS) store_coef(exponent, coef_value);
            end
            pe_pkg::OP_ADD: begin
                if (exponent < pe_pkg::TERMS) begin
                    acc = coefs[exponent];
                    acc = clamp_q(acc + coef_value, sat);
                    store_coef(exponent, acc[31:0]);
                end
            end
            pe_pkg::OP_CLR: begin
                wipe();
            end
            default: begin
                acc = '0;
                px  = point_x;
                for (int i = pe_pkg::TERMS - 1; i >= 0; i--) begin
                    // arithmetic shift gives truncation toward minus infinity
                    acc = clamp_q((acc * px) >>> 16, sat);
                    acc = clamp_q(acc + coefs[i], sat);
                end
                a.value = acc[31:0];
            end
        endcase
        a.degree = '0;
        for (int k = 0; k < 32; k++) begin
            if (marks[k]) a.degree = 5'(k);
        end
        a.overflow = sat;
        answers.push_back(a);
    endfunction

    function void check_answer(input pe_pkg::t_q value, input logic [4:0] degree,
                               input logic overflow);
        t_poly_answer a;
        if (answers.size() == 0) begin
            errors++;
            $display("%0t: result with no item pending: value %0d degree %0d overflow %0b",
                     $time, value, degree, overflow);
            return;
        end
        a = answers.pop_front();
        if (value !== a.value) begin
            errors++;
            $display("%0t: result_value mismatch: expected %0d, actual %0d",
                     $time, a.value, value);
        end
        if (degree !== a.degree) begin
            errors++;
            $display("%0t: poly_degree mismatch: expected %0d, actual %0d",
                     $time, a.degree, degree);
        end
        if (overflow !== a.overflow) begin
            errors++;
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, a.overflow, overflow);
        end
    endfunction
endclass

module tb_polynomial_evaluator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pe_pkg::*;

    localparam int RANDOM_OPS  = 550;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int TAIL_CYCLES = 80;

    localparam t_q Q_TOP    = 32'sh7FFF_FFFF;
    localparam t_q Q_BOTTOM = 32'sh8000_0000;
    localparam t_q ONE_Q    = 32'sh0001_0000;
    localparam t_q LSB_Q    = 32'sh0000_0001;
    localparam t_q MINUS_Q  = 32'shFFFF_FFFF;

    typedef enum int {RX_FREE, RX_RANDOM, RX_CHOKED} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pe_in_if  in_bus();
    pe_out_if out_bus();

    poly_scoreboard book = new();

    int       burst_left = 0;
    int       cycles = 0;
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;

    polynomial_evaluator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: switch between free flow, random stalls and heavy stalls.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   out_bus.ready <= 1'b1;
                RX_RANDOM: out_bus.ready <= 1'($urandom_range(0, 1));
                default:   out_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready)
                book.apply_operation(in_bus.operation, in_bus.exponent,
                                     in_bus.coef_value, in_bus.point_x);
            if (out_bus.valid && out_bus.ready)
                book.check_answer(out_bus.result_value, out_bus.poly_degree,
                                  out_bus.overflow);
        end
    end

    function automatic t_q pick_q(input int mag_bits);
        int span;
        int v;
        span = 1 << mag_bits;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return Q_TOP;
                    1:       return Q_BOTTOM;
                    2:       return '0;
                    3:       return LSB_Q;
                    4:       return MINUS_Q;
                    default: return ($urandom_range(0, 1) != 0) ? ONE_Q : -ONE_Q;
                endcase
            end
            1, 2: return t_q'($urandom);
            default: begin
                v = $urandom_range(0, 2 * span - 1);
                return t_q'(v - span);
            end
        endcase
    endfunction

    // Present one item, opening a new burst, usually after a random gap, when due.
    task automatic send_op(input logic [1:0] op, input logic [4:0] exponent,
                           input t_q coef_value, input t_q point_x);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                in_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        in_bus.valid      <= 1'b1;
        in_bus.operation  <= op;
        in_bus.exponent   <= exponent;
        in_bus.coef_value <= coef_value;
        in_bus.point_x    <= point_x;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (book.pending_count() != 0);
    endtask

    initial begin
        int         r;
        logic [1:0] op;
        logic [4:0] exponent;

        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.operation  <= OP_SET;
        in_bus.exponent   <= '0;
        in_bus.coef_value <= '0;
        in_bus.point_x    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store, extremes and both saturation directions of add.
        send_op(OP_EVAL, 5'd7, Q_TOP, Q_TOP);
        send_op(OP_SET, 5'd0, Q_TOP, Q_BOTTOM);
        send_op(OP_ADD, 5'd0, LSB_Q, '0);
        send_op(OP_SET, 5'd31, Q_BOTTOM, Q_TOP);
        send_op(OP_ADD, 5'd31, MINUS_Q, ONE_Q);
        send_op(OP_EVAL, 5'd31, Q_TOP, '0);
        send_op(OP_EVAL, 5'd0, Q_BOTTOM, ONE_Q);
        send_op(OP_EVAL, 5'd0, '0, Q_TOP);
        send_op(OP_EVAL, 5'd0, '0, Q_BOTTOM);
        // Drop the top term so the degree falls back.
        send_op(OP_SET, 5'd31, '0, MINUS_Q);
        // Small negative product must round toward minus infinity.
        send_op(OP_SET, 5'd1, LSB_Q, '0);
        send_op(OP_SET, 5'd0, '0, '0);
        send_op(OP_EVAL, 5'd0, '0, MINUS_Q);
        send_op(OP_EVAL, 5'd0, '0, LSB_Q);
        // Add back to zero clears the mark.
        send_op(OP_SET, 5'd3, 32'sd5, '0);
        send_op(OP_ADD, 5'd3, -32'sd5, '0);
        send_op(OP_SET, 5'd2, -ONE_Q, '0);
        send_op(OP_EVAL, 5'd17, Q_BOTTOM, 32'sh0002_0000);
        send_op(OP_CLR, 5'd31, Q_TOP, Q_BOTTOM);
        send_op(OP_EVAL, 5'd0, '0, -ONE_Q);
        send_op(OP_ADD, 5'd31, Q_TOP, '0);
        send_op(OP_ADD, 5'd31, Q_TOP, '0);
        send_op(OP_ADD, 5'd31, Q_BOTTOM, '0);
        send_op(OP_EVAL, 5'd0, '0, -ONE_Q);
        send_op(OP_CLR, 5'd0, '0, '0);
        hold_until_drained();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      op = OP_SET;
            else if (r < 52) op = OP_ADD;
            else if (r < 56) op = OP_CLR;
            else             op = OP_EVAL;
            // keep most terms low so evaluations stay mostly in range
            exponent = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 5))
                                                  : 5'($urandom_range(0, 31));
            send_op(op, exponent, pick_q(20), pick_q(17));
            if ($urandom_range(0, 49) == 0) hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/pe_pkg.sv
src/pe_if.sv
src/pe_coef_mem.sv
src/pe_mac.sv
src/polynomial_evaluator_top.sv
tb/tb_polynomial_evaluator_top.sv
